[rtl/rpc_pkg.sv]
// shared types and constants for the rigid pose composer
package rpc_pkg;

   localparam int MaxPartsDefault = 16;
   localparam int CountWidth = 5;
   localparam int IndexWidth = 4;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_MOVE = 1'b1;

   typedef struct packed {
      logic               func;
      logic [3:0]         entry_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] rot_w;
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_y;
      logic signed [15:0] rot_z;
   } req_type;

   typedef struct packed {
      logic [3:0]         part_index;
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
      logic signed [15:0] world_rot_w;
      logic signed [15:0] world_rot_x;
      logic signed [15:0] world_rot_y;
      logic signed [15:0] world_rot_z;
      logic               last_part;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [15:0] rw;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic signed [15:0] rz;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAT_A,
      ST_MAT_B,
      ST_MAT_C,
      ST_RUN
   } state_type;

   // q*v*q' matrix, entries at scale 2^20
   typedef struct packed {
      logic signed [25:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
   } mat_type;

   function automatic logic signed [25:0] rnd8(input logic signed [35:0] v);
      logic signed [35:0] t;
      t = v + 36'sd128;
      return t[33:8];
   endfunction

   // rotated offsets of non-unit quaternions reach about 2^37
   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      if (v > 40'sh00_7FFF_FFFF) return 32'sh7FFF_FFFF;
      else if (v < -40'sh00_8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [15:0] clip16(input logic signed [33:0] v);
      logic signed [33:0] t;
      logic signed [19:0] s;
      t = v + 34'sd8192;
      s = t[33:14];
      if (s > 20'sd32767) return 16'sh7FFF;
      else if (s < -20'sd32768) return 16'sh8000;
      return s[15:0];
   endfunction

endpackage

[rtl/rigid_pose_composer.sv]
// top level: relative pose table and move sequencer
//
// req_ channel: raise start with req_data; the item is taken at an edge where
// busy is low. a load item writes one table entry and gives no result, busy
// stays low. a move item gives one result per part in use (part_count,
// saturated to the table size and to 16), in index order, last one flagged.
// rsp_ channel: rsp_valid is high for one cycle per result; the receiver
// cannot stall, results are never held.
// csr_ channel: csr_valid/csr_ready write part_count (low 5 bits); csr_ready
// is high while the block is idle and start is low.
// sequence: a move passes through ST_MAT_A (ten 16x16 products), ST_MAT_B
// (the sums) and ST_MAT_C, then reads one table entry per cycle from the
// entry memory (registered read) into a three-stage pose pipeline; the
// results leave the ports one a cycle. busy stays high until the last
// result is out, or until the matrix states are done with a count of zero.
// reset: synchronous, clears the sequencer, part_count to 1; table
// contents are undefined until loaded.
module rigid_pose_composer #(
   parameter int MAX_PARTS = rpc_pkg::MaxPartsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rpc_pkg::req_type req_data,
   output logic             rsp_valid,
   output rpc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [4:0]       csr_data
);
   import rpc_pkg::*;

   localparam int AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int LIM = (MAX_PARTS < 16) ? MAX_PARTS : 16;

   entry_type          mem [MAX_PARTS];
   entry_type          rd_ff;
   state_type          state_ff, state_in;
   entry_type          base_ff;
   mat_type            mat_ff;
   logic signed [31:0] sq_ff [10];
   logic [CountWidth-1:0] count_ff, n_ff, ptr_ff, ptr_in;
   logic               rd_v_ff, rd_last_ff;
   logic [3:0]         rd_idx_ff;
   logic               issue;
   logic [3:0]         drain_ff;
   logic               accept;
   logic               pu_valid;
   rsp_type            pu_rsp;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;

   always_ff @(posedge clock) begin
      if (reset) count_ff <= CountWidth'(1);
      else if (csr_valid && csr_ready) count_ff <= csr_data;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (accept && req_data.func == FUNC_LOAD
          && 32'(req_data.entry_index) < 32'(MAX_PARTS)) begin
         mem[AW'(req_data.entry_index)] <= '{req_data.pos_x, req_data.pos_y,
            req_data.pos_z, req_data.rot_w, req_data.rot_x, req_data.rot_y,
            req_data.rot_z};
      end
      rd_ff <= mem[AW'(ptr_ff)];
   end

   assign issue = (state_ff == ST_RUN) && (ptr_ff < n_ff);

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      case (state_ff)
         ST_IDLE:  if (accept && req_data.func == FUNC_MOVE) state_in = ST_MAT_A;
         ST_MAT_A: state_in = ST_MAT_B;
         ST_MAT_B: state_in = ST_MAT_C;
         ST_MAT_C: begin
            state_in = ST_RUN;
            ptr_in = '0;
         end
         ST_RUN: begin
            if (issue) ptr_in = ptr_ff + 1'b1;
            else if (drain_ff == 4'd0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff <= '0;
         rd_v_ff <= 1'b0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         rd_v_ff <= issue;
         if (issue) drain_ff <= 4'd5;
         else if (drain_ff != 4'd0) drain_ff <= drain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= ptr_ff[3:0];
      rd_last_ff <= (ptr_ff + 1'b1 == n_ff);
      if (accept && req_data.func == FUNC_MOVE) begin
         base_ff <= '{req_data.pos_x, req_data.pos_y, req_data.pos_z,
            req_data.rot_w, req_data.rot_x, req_data.rot_y, req_data.rot_z};
         n_ff <= (32'(count_ff) > LIM) ? CountWidth'(LIM) : count_ff;
      end
      if (state_ff == ST_MAT_A) begin
         sq_ff[0] <= base_ff.rw * base_ff.rw;
         sq_ff[1] <= base_ff.rx * base_ff.rx;
         sq_ff[2] <= base_ff.ry * base_ff.ry;
         sq_ff[3] <= base_ff.rz * base_ff.rz;
         sq_ff[4] <= base_ff.rx * base_ff.ry;
         sq_ff[5] <= base_ff.rw * base_ff.rz;
         sq_ff[6] <= base_ff.rx * base_ff.rz;
         sq_ff[7] <= base_ff.rw * base_ff.ry;
         sq_ff[8] <= base_ff.ry * base_ff.rz;
         sq_ff[9] <= base_ff.rw * base_ff.rx;
      end
      if (state_ff == ST_MAT_B) begin
         mat_ff.m0 <= rnd8(36'(sq_ff[0]) + 36'(sq_ff[1]) - 36'(sq_ff[2]) - 36'(sq_ff[3]));
         mat_ff.m4 <= rnd8(36'(sq_ff[0]) - 36'(sq_ff[1]) + 36'(sq_ff[2]) - 36'(sq_ff[3]));
         mat_ff.m8 <= rnd8(36'(sq_ff[0]) - 36'(sq_ff[1]) - 36'(sq_ff[2]) + 36'(sq_ff[3]));
         mat_ff.m1 <= rnd8((36'(sq_ff[4]) - 36'(sq_ff[5])) <<< 1);
         mat_ff.m3 <= rnd8((36'(sq_ff[4]) + 36'(sq_ff[5])) <<< 1);
         mat_ff.m2 <= rnd8((36'(sq_ff[6]) + 36'(sq_ff[7])) <<< 1);
         mat_ff.m6 <= rnd8((36'(sq_ff[6]) - 36'(sq_ff[7])) <<< 1);
         mat_ff.m5 <= rnd8((36'(sq_ff[8]) - 36'(sq_ff[9])) <<< 1);
         mat_ff.m7 <= rnd8((36'(sq_ff[8]) + 36'(sq_ff[9])) <<< 1);
      end
   end

   rpc_pose_unit u_pose (
      .clock     (clock),
      .in_valid  (rd_v_ff),
      .in_index  (rd_idx_ff),
      .in_last   (rd_last_ff),
      .in_entry  (rd_ff),
      .mat       (mat_ff),
      .base      (base_ff),
      .reset     (reset),
      .out_valid (pu_valid),
      .out_rsp   (pu_rsp)
   );

   assign rsp_valid = pu_valid;
   assign rsp_data  = pu_rsp;
endmodule

[rtl/rpc_pose_unit.sv]
// pipelined pose arithmetic for one table entry: products, sums, rounding
module rpc_pose_unit (
   input  logic                clock,
   input  logic                in_valid,
   input  logic [3:0]          in_index,
   input  logic                in_last,
   input  rpc_pkg::entry_type  in_entry,
   input  rpc_pkg::mat_type    mat,
   input  rpc_pkg::entry_type  base,
   input  logic                reset,
   output logic                out_valid,
   output rpc_pkg::rsp_type    out_rsp
);
   import rpc_pkg::*;

   logic signed [57:0] prod_ff [9];
   logic signed [31:0] hp_ff [16];
   logic               v1_ff, v2_ff;
   logic [3:0]         idx1_ff;
   logic               last1_ff;
   logic signed [59:0] sum_ff [3];
   logic signed [33:0] q_ff [4];
   logic [3:0]         idx2_ff;
   logic               last2_ff;
   rsp_type            rsp_ff;
   logic               v3_ff;

   function automatic logic signed [39:0] rnd20(input logic signed [59:0] v);
      logic signed [59:0] t;
      t = v + 60'sd524288;
      return t[59:20];
   endfunction

   always_ff @(posedge clock) begin
      prod_ff[0] <= mat.m0 * in_entry.px;
      prod_ff[1] <= mat.m1 * in_entry.py;
      prod_ff[2] <= mat.m2 * in_entry.pz;
      prod_ff[3] <= mat.m3 * in_entry.px;
      prod_ff[4] <= mat.m4 * in_entry.py;
      prod_ff[5] <= mat.m5 * in_entry.pz;
      prod_ff[6] <= mat.m6 * in_entry.px;
      prod_ff[7] <= mat.m7 * in_entry.py;
      prod_ff[8] <= mat.m8 * in_entry.pz;
      hp_ff[0]  <= base.rw * in_entry.rw;
      hp_ff[1]  <= base.rx * in_entry.rx;
      hp_ff[2]  <= base.ry * in_entry.ry;
      hp_ff[3]  <= base.rz * in_entry.rz;
      hp_ff[4]  <= base.rw * in_entry.rx;
      hp_ff[5]  <= base.rx * in_entry.rw;
      hp_ff[6]  <= base.ry * in_entry.rz;
      hp_ff[7]  <= base.rz * in_entry.ry;
      hp_ff[8]  <= base.rw * in_entry.ry;
      hp_ff[9]  <= base.rx * in_entry.rz;
      hp_ff[10] <= base.ry * in_entry.rw;
      hp_ff[11] <= base.rz * in_entry.rx;
      hp_ff[12] <= base.rw * in_entry.rz;
      hp_ff[13] <= base.rx * in_entry.ry;
      hp_ff[14] <= base.ry * in_entry.rx;
      hp_ff[15] <= base.rz * in_entry.rw;
      idx1_ff  <= in_index;
      last1_ff <= in_last;
      for (int r = 0; r < 3; r++) begin
         sum_ff[r] <= 60'(prod_ff[3*r]) + 60'(prod_ff[3*r+1]) + 60'(prod_ff[3*r+2]);
      end
      q_ff[0] <= 34'(hp_ff[0]) - 34'(hp_ff[1]) - 34'(hp_ff[2]) - 34'(hp_ff[3]);
      q_ff[1] <= 34'(hp_ff[4]) + 34'(hp_ff[5]) + 34'(hp_ff[6]) - 34'(hp_ff[7]);
      q_ff[2] <= 34'(hp_ff[8]) - 34'(hp_ff[9]) + 34'(hp_ff[10]) + 34'(hp_ff[11]);
      q_ff[3] <= 34'(hp_ff[12]) + 34'(hp_ff[13]) - 34'(hp_ff[14]) + 34'(hp_ff[15]);
      idx2_ff  <= idx1_ff;
      last2_ff <= last1_ff;
      rsp_ff.part_index  <= idx2_ff;
      rsp_ff.world_x     <= sat32(40'(base.px) + rnd20(sum_ff[0]));
      rsp_ff.world_y     <= sat32(40'(base.py) + rnd20(sum_ff[1]));
      rsp_ff.world_z     <= sat32(40'(base.pz) + rnd20(sum_ff[2]));
      rsp_ff.world_rot_w <= clip16(q_ff[0]);
      rsp_ff.world_rot_x <= clip16(q_ff[1]);
      rsp_ff.world_rot_y <= clip16(q_ff[2]);
      rsp_ff.world_rot_z <= clip16(q_ff[3]);
      rsp_ff.last_part   <= last2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_rsp   = rsp_ff;
endmodule

[rtl/rpc_checker.sv]
// port-level checks for the rigid pose composer
module rpc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input rpc_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready
);
   import rpc_pkg::*;

   // results only come while a move is in progress
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside move");

   // a flagged last result ends the move
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_part |=> !rsp_valid) else $error("result after last");

   // consecutive results have increasing index
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_part ##1 rsp_valid
      |-> rsp_data.part_index == $past(rsp_data.part_index) + 4'd1)
      else $error("index skip");

   // no config write during a move
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy) else $error("csr ready while busy");

   // a config write never shares its edge with an item
   a_csr_no_item: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !start) else $error("csr write with item");
endmodule

bind rigid_pose_composer rpc_checker u_rpc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
